@@ rtl/mavf_pkg.sv @@
// shared types and constants for the moving average filter
`default_nettype none

package mavf_pkg;

   localparam int WINDOW_MAX = 64;
   localparam int PTR_W      = $clog2(WINDOW_MAX);
   localparam int CFG_W      = 7;
   localparam int SUM_W      = 38;
   localparam int DATA_W     = 32;
   localparam int CNT_SAT    = WINDOW_MAX + 1;
   localparam int CNT_W      = $clog2(CNT_SAT + 1);
   localparam int DIV_CNT_W  = $clog2(SUM_W);

   typedef struct packed {
      logic signed [DATA_W-1:0] sample;
      logic                     frame_end;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] average;
      logic                     frame_done;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_AVG,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic start;
      logic done;
   } div_ctrl_type;

endpackage

`default_nettype wire

@@ rtl/mavf_ring.sv @@
// window ring memory holding per-sample prefix sums, registered read
`default_nettype none

module mavf_ring (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire  [mavf_pkg::PTR_W-1:0]   wr_addr,
   input  wire  [mavf_pkg::SUM_W-1:0]   wr_data,
   input  wire                          rd_en,
   input  wire  [mavf_pkg::PTR_W-1:0]   rd_addr,
   output logic [mavf_pkg::SUM_W-1:0]   rd_data
);
   import mavf_pkg::*;

   logic [SUM_W-1:0] mem [WINDOW_MAX];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/mavf_div.sv @@
// radix-2 restoring divider, signed sum by window size, one quotient bit a cycle
`default_nettype none

module mavf_div (
   input  wire                                clock,
   input  wire                                reset,
   input  mavf_pkg::div_ctrl_type             ctrl_in,
   input  wire  signed [mavf_pkg::SUM_W-1:0]  dividend,
   input  wire  [mavf_pkg::CFG_W-1:0]         divisor,
   output mavf_pkg::div_ctrl_type             ctrl_out,
   output logic signed [mavf_pkg::DATA_W-1:0] quotient
);
   import mavf_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [CFG_W-1:0]     rem_ff, rem_in;
   logic [CFG_W-1:0]     div_ff, div_in;
   logic [CFG_W:0]       trial;
   logic [SUM_W-1:0]     quo_neg;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      if (ctrl_in.start) begin
         busy_in = 1'b1;
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = DIV_CNT_W'(SUM_W - 1);
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = CFG_W'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CFG_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quo_neg        = ~quo_ff + 1'b1;
   assign quotient       = neg_ff ? quo_neg[DATA_W-1:0] : quo_ff[DATA_W-1:0];
   assign ctrl_out.start = 1'b0;
   assign ctrl_out.done  = done_ff;

endmodule

`default_nettype wire

@@ rtl/moving_average_filter_top.sv @@
// moving average filter top level: frame control, prefix sum ring and result register
//
// A sample whose window is full passes through acceptance, the ring read,
// the divider (38 quotient bits, then a flag that the quotient is ready) and
// the hand-off of the average to the result register, which waits while that
// register still holds a result not yet taken. A sample whose window is not
// yet full passes through acceptance and the ring read and gives no average.
// On a frame's last sample the tail zeros follow one per cycle while the result
// register is free, up to window_size-1 of them. The ring stores running prefix
// sums of the frame, so a window sum is one subtract of two prefixes whatever the window size.
// A sample is taken while a previous result still waits in the result register.
`default_nettype none

module moving_average_filter_top (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  mavf_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output mavf_pkg::rsp_type             rsp_data,
   input  wire                           csr_wr_en,
   input  wire  [mavf_pkg::CFG_W-1:0]    csr_wr_data
);
   import mavf_pkg::*;

   state_type          state_ff, state_in;
   logic [CFG_W-1:0]   window_ff, window_in;
   logic [CFG_W-1:0]   w_ff, w_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [SUM_W-1:0]   prefix_ff, prefix_in;
   logic               last_ff, last_in;
   logic               full_ff, full_in;
   logic               over_ff, over_in;
   logic [CFG_W-1:0]   zero_cnt_ff, zero_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [CFG_W-1:0]   w_eff;
   logic [CNT_W-1:0]   count_next;
   logic               accept;
   logic               slot_free;
   logic               emit;
   logic [PTR_W-1:0]   rd_addr;
   logic [SUM_W-1:0]   rd_data;
   logic               ring_wr;
   logic signed [SUM_W-1:0] win_sum;
   div_ctrl_type       div_req, div_rsp;
   logic signed [DATA_W-1:0] div_quo;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      w_eff = window_ff;
      if (window_ff == '0) begin
         w_eff = CFG_W'(1);
      end else if (window_ff > CFG_W'(WINDOW_MAX)) begin
         w_eff = CFG_W'(WINDOW_MAX);
      end
   end

   assign count_next = (count_ff == CNT_W'(CNT_SAT)) ? count_ff : count_ff + 1'b1;
   assign rd_addr    = ptr_ff - w_eff[PTR_W-1:0];
   assign ring_wr    = (state_ff == ST_READ);
   assign win_sum    = over_ff ? (prefix_ff - rd_data) : prefix_ff;

   mavf_ring u_ring (
      .clock   (clock),
      .wr_en   (ring_wr),
      .wr_addr (ptr_ff),
      .wr_data (prefix_ff),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign div_req.start = (state_ff == ST_READ) && full_ff;
   assign div_req.done  = 1'b0;

   mavf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl_in  (div_req),
      .dividend (win_sum),
      .divisor  (w_ff),
      .ctrl_out (div_rsp),
      .quotient (div_quo)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (full_ff) begin
               state_in = ST_DIV;
            end else if (last_ff) begin
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_AVG;
            end
         end
         ST_AVG: begin
            if (slot_free) begin
               state_in = (last_ff && zero_cnt_ff != '0) ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (slot_free && zero_cnt_ff == CFG_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      emit         = 1'b0;
      window_in    = csr_wr_en ? csr_wr_data : window_ff;
      w_in         = w_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      prefix_in    = prefix_ff;
      last_in      = last_ff;
      full_in      = full_ff;
      over_in      = over_ff;
      zero_cnt_in  = zero_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               w_in      = w_eff;
               count_in  = count_next;
               prefix_in = prefix_ff + SUM_W'(req_data.sample);
               last_in   = req_data.frame_end;
               full_in   = count_next >= CNT_W'(w_eff);
               over_in   = count_next > CNT_W'(w_eff);
               zero_cnt_in = (count_next >= CNT_W'(w_eff)) ? (w_eff - 1'b1)
                                                           : CFG_W'(count_next);
            end
         end
         ST_READ: begin
            if (last_ff) begin
               count_in  = '0;
               ptr_in    = '0;
               prefix_in = '0;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_AVG: begin
            emit = slot_free;
            if (emit) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.average    = div_quo;
               rsp_data_in.frame_done = last_ff && (zero_cnt_ff == '0);
            end
         end
         ST_FLUSH: begin
            emit = slot_free;
            if (emit) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.average    = '0;
               rsp_data_in.frame_done = (zero_cnt_ff == CFG_W'(1));
               zero_cnt_in            = zero_cnt_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= CFG_W'(1);
         count_ff     <= '0;
         ptr_ff       <= '0;
         prefix_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         prefix_ff    <= prefix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      last_ff     <= last_in;
      full_ff     <= full_in;
      over_ff     <= over_in;
      zero_cnt_ff <= zero_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_reads : assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_READ)
      else $error("transfer in did not start a ring read");

   a_div_done_state : assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CNT_SAT))
      else $error("frame count beyond saturation");

   a_flush_nonzero : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH |-> zero_cnt_ff != '0)
      else $error("flush with no zeros left");

endmodule

`default_nettype wire

@@ sim/mavf_average_checker.sv @@
// checker for the moving average filter: predicts window averages and compares rsp transfers
module mavf_average_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  mavf_pkg::req_type          req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  mavf_pkg::rsp_type          rsp_data,
   input  logic                       csr_wr_en,
   input  logic [mavf_pkg::CFG_W-1:0] csr_wr_data,
   output int                         error_count,
   output int                         results_owed
);
   import mavf_pkg::*;

   logic signed [DATA_W-1:0] sample_hist [WINDOW_MAX];
   logic [CFG_W-1:0]         window_reg;
   int unsigned              frame_fill;
   logic [PTR_W-1:0]         write_slot;
   rsp_type                  expected_averages [$];

   task automatic predict_window_average(input req_type item);
      int unsigned width;
      int unsigned tail;
      longint      total;
      longint      quotient;
      rsp_type     res;
      rsp_type     step_out [$];
      width = (window_reg == 0) ? 1 : ((window_reg > WINDOW_MAX) ? WINDOW_MAX : window_reg);
      sample_hist[write_slot] = item.sample;
      if (frame_fill < WINDOW_MAX) frame_fill++;
      if (frame_fill >= width) begin
         total = 0;
         for (int k = 0; k < width; k++) begin
            total += longint'(sample_hist[PTR_W'(write_slot - k)]);
         end
         quotient = total / longint'(width);
         res.average = quotient[DATA_W-1:0];
         res.frame_done = 1'b0;
         step_out.push_back(res);
         tail = width - 1;
      end else begin
         tail = frame_fill;
      end
      write_slot = write_slot + 1'b1;
      if (item.frame_end) begin
         res = '0;
         repeat (tail) step_out.push_back(res);
         res = step_out.pop_back();
         res.frame_done = 1'b1;
         step_out.push_back(res);
         frame_fill = 0;
         write_slot = '0;
      end
      foreach (step_out[i]) expected_averages.push_back(step_out[i]);
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         window_reg = 7'd1;
         frame_fill = 0;
         write_slot = '0;
         expected_averages.delete();
         error_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_averages.size() == 0) begin
               $error("rsp transfer with nothing expected: average %0d frame_done %0b",
                      rsp_data.average, rsp_data.frame_done);
               error_count++;
            end else begin
               want = expected_averages.pop_front();
               if (rsp_data.average !== want.average) begin
                  $error("average: expected %0d, actual %0d", want.average, rsp_data.average);
                  error_count++;
               end
               if (rsp_data.frame_done !== want.frame_done) begin
                  $error("frame_done: expected %0b, actual %0b",
                         want.frame_done, rsp_data.frame_done);
                  error_count++;
               end
            end
         end
         if (csr_wr_en) window_reg = csr_wr_data;
         if (req_valid && req_ready) predict_window_average(req_data);
      end
      results_owed = expected_averages.size();
   end

endmodule

@@ sim/tb_moving_average_filter_top.sv @@
// testbench top for the moving average filter: stimulus, receiver stalls and verdict
module tb_moving_average_filter_top;
   import mavf_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 10_000_000;
   localparam int          SETTLE_CYCLES   = 60;
   localparam int          HOLD_CYCLES     = 400;
   localparam int          ITEMS_PER_PHASE = 35;
   localparam int          PHASE_COUNT     = 10;

   typedef enum {
      STYLE_RANDOM,
      STYLE_SMALL,
      STYLE_MAX,
      STYLE_MIN,
      STYLE_CORNERS
   } sample_style_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              csr_wr_en;
   logic [CFG_W-1:0]  csr_wr_data;
   int                error_count;
   int                results_owed;
   int unsigned       cycle_count = 0;
   bit                hold_wanted = 1'b0;
   bit                sender_steady = 1'b0;

   moving_average_filter_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   mavf_average_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .error_count  (error_count),
      .results_owed (results_owed)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int unsigned idle_length();
      if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
      return $urandom_range(1, 4);
   endfunction

   function automatic int unsigned effective_width(logic [CFG_W-1:0] value);
      if (value == 0) return 1;
      if (value > WINDOW_MAX) return WINDOW_MAX;
      return value;
   endfunction

   function automatic int unsigned frame_length(int unsigned width);
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 2) return 1;
      if (r < 4) return $urandom_range(1, width);
      if (r < 8) return $urandom_range(width, width + 20);
      return $urandom_range(1, 140);
   endfunction

   function automatic sample_style_type pick_style();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 10) return STYLE_RANDOM;
      if (r < 13) return STYLE_SMALL;
      if (r < 15) return STYLE_MAX;
      if (r < 17) return STYLE_MIN;
      return STYLE_CORNERS;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_sample(sample_style_type style);
      case (style)
         STYLE_SMALL: return $urandom_range(0, 20) - 10;
         STYLE_MAX: return 32'sh7fffffff;
         STYLE_MIN: return 32'sh80000000;
         STYLE_CORNERS: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7fffffff;
               1: return 32'sh80000000;
               2: return 32'sh0;
               default: return -32'sd1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // one req transfer, valid held until accepted
   task automatic put_item(input logic signed [DATA_W-1:0] sample, input logic last);
      int unsigned gap;
      if (!sender_steady && $urandom_range(0, 9) >= 6) begin
         gap = idle_length();
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data = '{sample: sample, frame_end: last};
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_window(input logic [CFG_W-1:0] value);
      req_valid = 1'b0;
      while (results_owed != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   initial begin : receiver
      int unsigned stall_left;
      int unsigned steady_left;
      int unsigned r;
      bit          hold_done;
      stall_left = 0;
      steady_left = 0;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_wanted && !hold_done) begin
            // long hold-off so the block backs up into req
            hold_done = 1'b1;
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (steady_left != 0) begin
            steady_left--;
            rsp_ready = 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_ready = 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 3) steady_left = $urandom_range(40, 200);
            else if (r < 30) stall_left = idle_length();
            rsp_ready = (stall_left == 0);
         end
      end
   end

   initial begin : stimulus
      logic [CFG_W-1:0] phase_windows [PHASE_COUNT];
      int unsigned      frame_left;
      int unsigned      width;
      sample_style_type style;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      phase_windows = '{7'd2, 7'd64, 7'd5, 7'd127, 7'd1, 7'd65, 7'd0, 7'd3, 7'd2, 7'd2};
      phase_windows[8] = $urandom_range(1, 64);
      phase_windows[9] = $urandom_range(1, 127);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // window of one at its reset value
      put_item(32'sh7fffffff, 1'b0);
      put_item(32'sh80000000, 1'b0);
      put_item(32'sh0, 1'b1);
      put_item(-32'sd1, 1'b1);

      // frame shorter than the window, then full windows at both extremes
      write_window(7'd4);
      put_item(32'sd5, 1'b0);
      put_item(32'sd9, 1'b1);
      repeat (4) put_item(32'sh7fffffff, 1'b0);
      repeat (3) put_item(32'sh80000000, 1'b0);
      put_item(32'sh80000000, 1'b1);

      // negative sums truncate toward zero
      put_item(-32'sd1, 1'b0);
      put_item(-32'sd2, 1'b0);
      put_item(32'sd0, 1'b0);
      put_item(32'sd0, 1'b0);
      put_item(-32'sd7, 1'b0);
      put_item(32'sd0, 1'b0);
      put_item(32'sd0, 1'b0);
      put_item(32'sd0, 1'b1);

      // window size zero acts as one
      write_window(7'd0);
      put_item(32'sd3, 1'b0);
      put_item(-32'sd3, 1'b1);

      frame_left = 0;
      style = STYLE_RANDOM;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_window(phase_windows[p]);
         width = effective_width(phase_windows[p]);
         sender_steady = (p % 3 == 2);
         if (p == 0) hold_wanted = 1'b1;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (frame_left == 0) begin
               frame_left = frame_length(width);
               style = pick_style();
            end
            put_item(pick_sample(style), frame_left == 1);
            frame_left--;
         end
      end

      req_valid = 1'b0;
      while (results_owed != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (error_count == 0 && results_owed == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
